>>> sv/brdw_pkg.sv
package brdw_pkg;

  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned IN_VALUE_W     = 16;
  localparam int unsigned RADIX_W        = 4;
  localparam int unsigned WORD_W         = 50;
  localparam int unsigned DIGIT_W        = 4;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 4'd10;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value_in;
    logic [RADIX_W-1:0]    radix;
  } brdw_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] digit_word;
    logic              bad_radix;
  } brdw_out_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic fix;
  } brdw_cmd_t;

  typedef struct packed {
    logic num_zero;
    logic bad;
  } brdw_stat_t;

endpackage

>>> sv/binary_to_radix_digit_word.sv
// Converts an unsigned number to a base from 2 to 10 by repeated division.
// The digits are placed at decimal weights, so the decimal spelling of
// digit_word reads as the digits in the requested base.
// Input channel: a transaction is taken at a rising edge where start is high
// and busy is low; item_i carries value_in and radix.
// Output channel: valid_o is high for exactly one cycle with result_o; the
// receiver must take it then, as there is no way to hold the result back.
// Each digit takes a reciprocal multiply step and then a remainder correction
// step, which makes the iteration loop the limit on rate.
// A zero value, or a radix outside 2 to 10, goes from its first multiply step
// straight to the result strobe.
// A new transaction is accepted in the cycle after the result strobe.
// A radix outside 2 to 10 sets bad_radix with a zero digit word.
// Reset returns the controller to idle; no result is pending afterwards.
module binary_to_radix_digit_word #(
  parameter int unsigned VALUE_BITS = brdw_pkg::VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  brdw_pkg::brdw_in_t  item_i,
  output logic                valid_o,
  output brdw_pkg::brdw_out_t result_o
);

  brdw_pkg::brdw_cmd_t  cmd;
  brdw_pkg::brdw_stat_t stat;

  brdw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy    (busy),
    .valid_o (valid_o)
  );

  brdw_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o)
  );

endmodule

>>> sv/brdw_ctrl.sv
module brdw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  brdw_pkg::brdw_stat_t stat_i,
  output brdw_pkg::brdw_cmd_t  cmd_o,
  output logic                busy,
  output logic                valid_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.mul  = 1'b0;
    cmd_o.fix  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (stat_i.num_zero || stat_i.bad) begin
          state_d = S_DONE;
        end else begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_MUL;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = (state_q == S_DONE);

  // A result strobe lasts a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  // An accepted transaction makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // A result is only issued straight after a multiply step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_o |-> $past(state_q == S_MUL))
    else $error("result strobe without a preceding multiply step");

  // Correction and load never occur together with a multiply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $countones({cmd_o.load, cmd_o.mul, cmd_o.fix}) <= 1)
    else $error("conflicting datapath commands");

endmodule

>>> sv/brdw_dp.sv
module brdw_dp #(
  parameter int unsigned VALUE_BITS = brdw_pkg::VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  brdw_pkg::brdw_in_t   item_i,
  input  brdw_pkg::brdw_cmd_t  cmd_i,
  output brdw_pkg::brdw_stat_t stat_o,
  output brdw_pkg::brdw_out_t  result_o
);

  localparam int unsigned WW = brdw_pkg::WORD_W;
  localparam int unsigned DW = brdw_pkg::DIGIT_W;
  localparam int unsigned RW = brdw_pkg::RADIX_W;
  localparam logic [63:0] SCALE = 64'd1 << VALUE_BITS;
  localparam logic [VALUE_BITS-1:0] RECIP2  = VALUE_BITS'(SCALE / 64'd2);
  localparam logic [VALUE_BITS-1:0] RECIP3  = VALUE_BITS'(SCALE / 64'd3);
  localparam logic [VALUE_BITS-1:0] RECIP4  = VALUE_BITS'(SCALE / 64'd4);
  localparam logic [VALUE_BITS-1:0] RECIP5  = VALUE_BITS'(SCALE / 64'd5);
  localparam logic [VALUE_BITS-1:0] RECIP6  = VALUE_BITS'(SCALE / 64'd6);
  localparam logic [VALUE_BITS-1:0] RECIP7  = VALUE_BITS'(SCALE / 64'd7);
  localparam logic [VALUE_BITS-1:0] RECIP8  = VALUE_BITS'(SCALE / 64'd8);
  localparam logic [VALUE_BITS-1:0] RECIP9  = VALUE_BITS'(SCALE / 64'd9);
  localparam logic [VALUE_BITS-1:0] RECIP10 = VALUE_BITS'(SCALE / 64'd10);

  logic [VALUE_BITS-1:0]   num_q;
  logic [RW-1:0]           radix_q;
  logic [VALUE_BITS-1:0]   recip_q;
  logic [2*VALUE_BITS-1:0] prod_q;
  logic [DW-1:0]           digit_q;
  logic [WW-1:0]           weight_q;
  logic [WW-1:0]           acc_q;
  logic                    first_q;
  logic                    bad_q;

  logic                  bad_d;
  logic [VALUE_BITS-1:0] recip_d;
  logic [VALUE_BITS-1:0] q_est;
  logic [VALUE_BITS-1:0] qb;
  logic [VALUE_BITS-1:0] r_full;
  logic [DW:0]           r_est;
  logic [VALUE_BITS-1:0] q_fix;
  logic [DW:0]           r_fix;

  always_comb begin
    bad_d = !(item_i.radix inside {[brdw_pkg::RADIX_MIN:brdw_pkg::RADIX_MAX]});
    case (item_i.radix)
      4'd3:    recip_d = RECIP3;
      4'd4:    recip_d = RECIP4;
      4'd5:    recip_d = RECIP5;
      4'd6:    recip_d = RECIP6;
      4'd7:    recip_d = RECIP7;
      4'd8:    recip_d = RECIP8;
      4'd9:    recip_d = RECIP9;
      4'd10:   recip_d = RECIP10;
      default: recip_d = RECIP2;
    endcase
  end

  // The reciprocal estimate is at most one below the true quotient.
  always_comb begin
    q_est  = prod_q[2*VALUE_BITS-1:VALUE_BITS];
    qb     = VALUE_BITS'(q_est * VALUE_BITS'(radix_q));
    r_full = num_q - qb;
    r_est  = (DW+1)'(r_full);
    if (r_est >= {1'b0, radix_q}) begin
      q_fix = q_est + VALUE_BITS'(1);
      r_fix = r_est - {1'b0, radix_q};
    end else begin
      q_fix = q_est;
      r_fix = r_est;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q    <= VALUE_BITS'(item_i.value_in);
      radix_q  <= item_i.radix;
      recip_q  <= recip_d;
      bad_q    <= bad_d;
      digit_q  <= '0;
      weight_q <= WW'(1);
      acc_q    <= '0;
      first_q  <= 1'b1;
    end
    if (cmd_i.mul) begin
      prod_q <= num_q * recip_q;
      acc_q  <= acc_q + WW'(weight_q * WW'(digit_q));
    end
    if (cmd_i.fix) begin
      num_q   <= q_fix;
      digit_q <= DW'(r_fix);
      first_q <= 1'b0;
      if (!first_q) begin
        weight_q <= (weight_q << 3) + (weight_q << 1);
      end
    end
  end

  assign stat_o.num_zero     = (num_q == '0);
  assign stat_o.bad          = bad_q;
  assign result_o.digit_word = acc_q;
  assign result_o.bad_radix  = bad_q;

  logic fix_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_seen_q <= 1'b0;
    end else begin
      fix_seen_q <= cmd_i.fix;
    end
  end

  // Every digit produced is a valid digit of the base.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   fix_seen_q |-> (digit_q < radix_q))
    else $error("digit not below the radix");

  // A rejected radix never accumulates anything.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (fix_seen_q || cmd_i.mul) && bad_q |-> (acc_q == '0))
    else $error("non-zero digit word for a rejected radix");

endmodule

>>> verif/tb_binary_to_radix_digit_word.sv
module tb_binary_to_radix_digit_word;

  localparam int unsigned VALUE_BITS  = brdw_pkg::VALUE_BITS_DEF;
  localparam int          STALL_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 40;
  localparam int          PHASE_ITEMS = 617;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                drv_start = 1'b0;
  brdw_pkg::brdw_in_t  drv_item = '0;
  logic                busy;
  logic                valid_o;
  brdw_pkg::brdw_out_t dut_result;

  logic      in_took = 1'b0;
  int        gap_pct = 0;
  int        items_queued = 0;
  int        items_taken = 0;
  int        fail_cnt = 0;
  int        stall_cnt = 0;

  brdw_pkg::brdw_in_t  send_q[$];
  brdw_pkg::brdw_out_t word_exp_q[$];

  binary_to_radix_digit_word #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (drv_start),
    .busy    (busy),
    .item_i  (drv_item),
    .valid_o (valid_o),
    .result_o(dut_result)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Spells the value in the requested base, one digit per decimal place.
  function automatic brdw_pkg::brdw_out_t spell_radix(brdw_pkg::brdw_in_t it);
    brdw_pkg::brdw_out_t res;
    logic [63:0] num;
    logic [63:0] base;
    logic [63:0] acc;
    logic [63:0] weight;
    num    = 64'(it.value_in) & ((64'd1 << VALUE_BITS) - 64'd1);
    base   = 64'(it.radix);
    acc    = '0;
    weight = 64'd1;
    res    = '0;
    if (it.radix < brdw_pkg::RADIX_MIN || it.radix > brdw_pkg::RADIX_MAX) begin
      res.bad_radix = 1'b1;
    end else begin
      while (num != 0) begin
        acc    = acc + weight * (num % base);
        num    = num / base;
        weight = weight * 64'd10;
      end
      res.digit_word = acc[brdw_pkg::WORD_W-1:0];
    end
    return res;
  endfunction

  task automatic queue_item(logic [brdw_pkg::IN_VALUE_W-1:0] value,
                            logic [brdw_pkg::RADIX_W-1:0] radix);
    brdw_pkg::brdw_in_t it;
    it.value_in = value;
    it.radix    = radix;
    send_q.push_back(it);
    items_queued++;
  endtask

  task automatic queue_random_item();
    logic [brdw_pkg::IN_VALUE_W-1:0] value;
    logic [brdw_pkg::RADIX_W-1:0]    radix;
    case ($urandom_range(3))
      0: value = brdw_pkg::IN_VALUE_W'($urandom_range(15));
      1: value = brdw_pkg::IN_VALUE_W'(1) << $urandom_range(brdw_pkg::IN_VALUE_W - 1);
      2: value = $urandom_range(1) ? '1 : brdw_pkg::IN_VALUE_W'($urandom_range(255));
      default: value = brdw_pkg::IN_VALUE_W'($urandom);
    endcase
    if ($urandom_range(99) < 85) begin
      radix = brdw_pkg::RADIX_W'($urandom_range(brdw_pkg::RADIX_MAX, brdw_pkg::RADIX_MIN));
    end else begin
      radix = brdw_pkg::RADIX_W'($urandom_range(15));
    end
    queue_item(value, radix);
  endtask

  // Waits at the falling edge until every queued transaction is accepted and answered.
  task automatic wait_drained();
    @(negedge clk_i);
    while (items_taken != items_queued || word_exp_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin
    logic               go;
    brdw_pkg::brdw_in_t nxt;
    go  = drv_start;
    nxt = drv_item;
    if (!drv_start || in_took) begin
      go = 1'b0;
      if (rst_ni && send_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = send_q.pop_front();
        go  = 1'b1;
      end
    end
    drv_start <= go;
    drv_item  <= nxt;
  end

  always @(posedge clk_i) begin
    brdw_pkg::brdw_out_t want;
    in_took <= rst_ni && drv_start && !busy;
    if (rst_ni && valid_o) begin
      if (word_exp_q.size() == 0) begin
        fail_cnt++;
        $display("%0t unexpected result: expected none, actual digit_word %0d bad_radix %0b",
                 $time, dut_result.digit_word, dut_result.bad_radix);
      end else begin
        want = word_exp_q.pop_front();
        if (dut_result.digit_word !== want.digit_word) begin
          fail_cnt++;
          $display("%0t digit_word mismatch: expected %0d, actual %0d",
                   $time, want.digit_word, dut_result.digit_word);
        end
        if (dut_result.bad_radix !== want.bad_radix) begin
          fail_cnt++;
          $display("%0t bad_radix mismatch: expected %0b, actual %0b",
                   $time, want.bad_radix, dut_result.bad_radix);
        end
      end
    end
    if (rst_ni && drv_start && !busy) begin
      word_exp_q.push_back(spell_radix(drv_item));
      items_taken++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (drv_start && !busy) || valid_o) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    wait (stall_cnt >= STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 25 : (phase == 1) ? 53 : 0;
      if (phase == 0) begin
        queue_item('0, brdw_pkg::RADIX_MIN);
        queue_item('0, brdw_pkg::RADIX_MAX);
        queue_item('0, 4'd0);
        for (int r = 0; r < 16; r++) begin
          queue_item('1, brdw_pkg::RADIX_W'(r));
        end
        queue_item(16'd1, brdw_pkg::RADIX_MIN);
        queue_item(16'd9, brdw_pkg::RADIX_MAX);
        queue_item(16'd10, brdw_pkg::RADIX_MAX);
        queue_item(16'h5555, 4'd3);
        queue_item(16'hAAAA, 4'd7);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_random_item();
      end
      // No further items are queued here until every queued item is accepted and its result has arrived.
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_cnt == 0 && word_exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/brdw_pkg.sv
sv/brdw_ctrl.sv
sv/brdw_dp.sv
sv/binary_to_radix_digit_word.sv
verif/tb_binary_to_radix_digit_word.sv
